@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ design/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsm_pkg
// Constants, types and small tables of the 3x3 RGB box smoothing unit.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int MAX_SIDE  = 1024;
  localparam int COL_W     = $clog2(MAX_SIDE);
  localparam int BANK_W    = 2;
  localparam int ADDR_W    = BANK_W + COL_W;
  localparam int RAM_DEPTH = 3 * MAX_SIDE;
  localparam int SIDE_W    = 11;
  localparam int CH_W      = 16;
  localparam int PIX_W     = 3 * CH_W;
  localparam int SUM_W     = 20;
  localparam int N_W       = 4;
  localparam int TAP_W     = 4;
  localparam int NUM_TAPS  = 9;
  localparam int NUM_TGT   = 4;
  localparam int TGT_W     = 3;

  // Reciprocals of the window counts, exact for any sum below 2**21
  localparam int RCP_W  = 21;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam int SHF_W  = 5;
  localparam int RCP_SH = 20;
  localparam logic [RCP_W-1:0] RCP_ONE = RCP_W'(1 << RCP_SH);
  localparam logic [RCP_W-1:0] RCP_3   = RCP_W'(699051);
  localparam logic [RCP_W-1:0] RCP_9   = RCP_W'(932068);

  localparam logic [SIDE_W-1:0] SIDE_RST = SIDE_W'(512);

  typedef struct packed {
    logic              accept;
    logic              tgt_start;
    logic [1:0]        tgt_sel;
    logic              tap_vld;
    logic [TAP_W-1:0]  tap;
    logic              div_start;
    logic              out_load;
  } bsm_cmd_t;

  typedef struct packed {
    logic [NUM_TGT-1:0] tgt_en;
    logic               out_full;
  } bsm_sts_t;

  // Window row of a tap: 0 above, 1 centre, 2 below
  function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] tap);
    logic [1:0] r;
    case (tap)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Window column of a tap: 0 left, 1 centre, 2 right
  function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] tap);
    logic [1:0] c;
    case (tap)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic [BANK_W-1:0] bank_inc(input logic [BANK_W-1:0] b);
    return (b == 2'd2) ? 2'd0 : b + 2'd1;
  endfunction

  function automatic logic [BANK_W-1:0] bank_dec(input logic [BANK_W-1:0] b);
    return (b == 2'd0) ? 2'd2 : b - 2'd1;
  endfunction

endpackage

@@ design/bsm_ram.sv @@
// ----------------------------------------------------------------------------
// bsm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bsm_datapath.sv @@
// ----------------------------------------------------------------------------
// bsm_datapath
// Line store, raster counters, window accumulator, divider and result register.
// ----------------------------------------------------------------------------
module bsm_datapath import bsm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SIDE_W-1:0]   cfg_side_i,
  input  logic [PIX_W-1:0]    pix_i,
  input  bsm_cmd_t            cmd_i,
  output bsm_sts_t            sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PIX_W-1:0]    out_pix_o,
  output logic [COL_W-1:0]    out_row_o,
  output logic [COL_W-1:0]    out_col_o,
  output logic                out_last_o
);

  logic [SIDE_W-1:0] side_q;
  logic [COL_W-1:0]  row_q, col_q, sm1;
  logic [BANK_W-1:0] bank_q;
  logic [COL_W-1:0]  cur_r_q, cur_c_q;
  logic [BANK_W-1:0] cur_b_q;
  logic [COL_W-1:0]  tr_q, tc_q;
  logic [BANK_W-1:0] tb_q;
  logic              tv_q;
  logic [SUM_W-1:0]  sum_q [3];
  logic [N_W-1:0]    cnt_q;
  logic [CH_W-1:0]   quo_q [3];
  logic [CH_W-1:0]   quo_d [3];
  logic [PROD_W-1:0] prod [3];
  logic [RCP_W-1:0]  rcp;
  logic [SHF_W-1:0]  shamt;
  logic              ov_q;
  logic [PIX_W-1:0]  opix_q;
  logic [COL_W-1:0]  orow_q, ocol_q;
  logic              olast_q;

  logic [1:0]        trow, tcol;
  logic              row_ok, col_ok;
  logic [COL_W-1:0]  rcol;
  logic [BANK_W-1:0] rbank;
  logic [PIX_W-1:0]  rdata;

  // Effective side minus one, clipped to the supported range
  always_comb begin
    if (side_q == '0) begin
      sm1 = '0;
    end else if (int'(side_q) > MAX_SIDE) begin
      sm1 = COL_W'(MAX_SIDE - 1);
    end else begin
      sm1 = COL_W'(side_q - SIDE_W'(1));
    end
  end

  bsm_ram #(.WIDTH(PIX_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i ({bank_q, col_q}),
    .wdata_i (pix_i),
    .raddr_i ({rbank, rcol}),
    .rdata_o (rdata)
  );

  // Window tap address and clipping
  always_comb begin
    trow = tap_row(cmd_i.tap);
    tcol = tap_col(cmd_i.tap);
    row_ok = 1'b1;
    col_ok = 1'b1;
    rbank  = tb_q;
    rcol   = tc_q;
    case (trow)
      2'd0: begin
        row_ok = (tr_q != '0);
        rbank  = bank_dec(tb_q);
      end
      2'd2: begin
        row_ok = (tr_q != sm1);
        rbank  = bank_inc(tb_q);
      end
      default: ;
    endcase
    case (tcol)
      2'd0: begin
        col_ok = (tc_q != '0);
        rcol   = tc_q - COL_W'(1);
      end
      2'd2: begin
        col_ok = (tc_q != sm1);
        rcol   = tc_q + COL_W'(1);
      end
      default: ;
    endcase
  end

  // Divide by the window count: multiply by its reciprocal, then shift
  always_comb begin
    unique case (cnt_q)
      N_W'(1): begin
        rcp   = RCP_ONE;
        shamt = SHF_W'(RCP_SH);
      end
      N_W'(2): begin
        rcp   = RCP_ONE;
        shamt = SHF_W'(RCP_SH + 1);
      end
      N_W'(3): begin
        rcp   = RCP_3;
        shamt = SHF_W'(RCP_SH + 1);
      end
      N_W'(4): begin
        rcp   = RCP_ONE;
        shamt = SHF_W'(RCP_SH + 2);
      end
      N_W'(6): begin
        rcp   = RCP_3;
        shamt = SHF_W'(RCP_SH + 2);
      end
      default: begin
        rcp   = RCP_9;
        shamt = SHF_W'(RCP_SH + 3);
      end
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]  = PROD_W'(sum_q[ch]) * PROD_W'(rcp);
      quo_d[ch] = CH_W'(prod[ch] >> shamt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RST;
      row_q  <= '0;
      col_q  <= '0;
      bank_q <= '0;
      tv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      tv_q <= cmd_i.tap_vld & row_ok & col_ok;
      if (cfg_we_i) begin
        side_q <= cfg_side_i;
        row_q  <= '0;
        col_q  <= '0;
        bank_q <= '0;
      end else if (cmd_i.accept) begin
        if (col_q == sm1) begin
          col_q <= '0;
          if (row_q == sm1) begin
            row_q  <= '0;
            bank_q <= '0;
          end else begin
            row_q  <= row_q + COL_W'(1);
            bank_q <= bank_inc(bank_q);
          end
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_r_q <= row_q;
      cur_c_q <= col_q;
      cur_b_q <= bank_q;
    end
    if (cmd_i.tgt_start) begin
      tr_q <= cmd_i.tgt_sel[1] ? cur_r_q : cur_r_q - COL_W'(1);
      tb_q <= cmd_i.tgt_sel[1] ? cur_b_q : bank_dec(cur_b_q);
      tc_q <= cmd_i.tgt_sel[0] ? cur_c_q : cur_c_q - COL_W'(1);
      cnt_q <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch] <= '0;
      end
    end else if (tv_q) begin
      cnt_q <= cnt_q + N_W'(1);
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch] <= sum_q[ch] + SUM_W'(rdata[ch*CH_W +: CH_W]);
      end
    end
    if (cmd_i.div_start) begin
      for (int ch = 0; ch < 3; ch++) begin
        quo_q[ch] <= quo_d[ch];
      end
    end
    if (cmd_i.out_load) begin
      for (int ch = 0; ch < 3; ch++) begin
        opix_q[ch*CH_W +: CH_W] <= quo_q[ch];
      end
      orow_q  <= tr_q;
      ocol_q  <= tc_q;
      olast_q <= (tr_q == sm1) && (tc_q == sm1);
    end
  end

  assign sts_o.tgt_en[0] = (cur_r_q != '0) && (cur_c_q != '0);
  assign sts_o.tgt_en[1] = (cur_r_q != '0) && (cur_c_q == sm1);
  assign sts_o.tgt_en[2] = (cur_r_q == sm1) && (cur_c_q != '0);
  assign sts_o.tgt_en[3] = (cur_r_q == sm1) && (cur_c_q == sm1);
  assign sts_o.out_full  = ov_q;

  assign out_valid_o = ov_q;
  assign out_pix_o   = opix_q;
  assign out_row_o   = orow_q;
  assign out_col_o   = ocol_q;
  assign out_last_o  = olast_q;

endmodule

@@ design/bsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsm_ctrl
// Sequencer: walks the results of one pixel through taps, divide and output.
// ----------------------------------------------------------------------------
module bsm_ctrl import bsm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  bsm_sts_t sts_i,
  output bsm_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SEL, S_TAP, S_DRAIN, S_DSTART, S_OUT
  } state_e;

  state_e           state_q;
  logic [TGT_W-1:0] tgt_q;
  logic [TAP_W-1:0] tap_q;

  always_comb begin
    cfg_ready_o = (state_q == S_IDLE);
    in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
    cmd_o = '0;
    cmd_o.accept    = in_valid_i && in_ready_o;
    cmd_o.tgt_sel   = tgt_q[1:0];
    cmd_o.tap       = tap_q;
    cmd_o.tgt_start = (state_q == S_SEL) && (tgt_q != TGT_W'(NUM_TGT)) &&
                      sts_i.tgt_en[tgt_q[1:0]];
    cmd_o.tap_vld   = (state_q == S_TAP);
    cmd_o.div_start = (state_q == S_DSTART);
    cmd_o.out_load  = (state_q == S_OUT) && !sts_i.out_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tgt_q   <= '0;
      tap_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.accept) begin
            tgt_q   <= '0;
            state_q <= S_SEL;
          end
        end
        S_SEL: begin
          if (tgt_q == TGT_W'(NUM_TGT)) begin
            state_q <= S_IDLE;
          end else if (sts_i.tgt_en[tgt_q[1:0]]) begin
            tap_q   <= '0;
            state_q <= S_TAP;
          end else begin
            tgt_q <= tgt_q + TGT_W'(1);
          end
        end
        S_TAP: begin
          if (tap_q == TAP_W'(NUM_TAPS - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            tap_q <= tap_q + TAP_W'(1);
          end
        end
        S_DRAIN:  state_q <= S_DSTART;
        S_DSTART: state_q <= S_OUT;
        S_OUT: begin
          if (!sts_i.out_full) begin
            tgt_q   <= tgt_q + TGT_W'(1);
            state_q <= S_SEL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/rgb_box_smooth_3x3_unit.sv @@
// An accepted request passes through target select, 9 line-store reads, drain,
// reciprocal divide and output load before its first result; each target
// skipped before it adds a step in target select. A pixel yields up to four
// results, at row and frame end, and a new pixel waits until the last is done;
// a result waiting for the sink holds the sequencer.
// Reset: counters clear, image side returns to 512, line store is not cleared.
// ----------------------------------------------------------------------------
// rgb_box_smooth_3x3_unit
// Streaming 3x3 box mean over a square RGB image, results tagged with position.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rgb_box_smooth_3x3_unit import bsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // in_red, in_green, in_blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_red, out_green, out_blue, out_row, out_col
  output logic        m_axis_tlast,   // frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data        // image_side in [10:0]
);

  bsm_cmd_t         cmd;
  bsm_sts_t         sts;
  logic [PIX_W-1:0] opix;
  logic [COL_W-1:0] orow, ocol;

  bsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bsm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid && cfg_ready),
    .cfg_side_i  (cfg_data[SIDE_W-1:0]),
    .pix_i       (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (opix),
    .out_row_o   (orow),
    .out_col_o   (ocol),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, ocol, orow, opix};

  // Hold off new pixels while one is in work
  `ASSERT_NEXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // Never overwrite a result still waiting
  `ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, cmd.out_load, !sts.out_full)
  // Frame end lies on the diagonal
  `ASSERT_IMPL(a_last_diag, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, orow == ocol)

endmodule

@@ verif/tb_rgb_box_smooth_3x3_unit.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_box_smooth_3x3_unit
// Streams whole and partial frames of RGB pixels through the 3x3 box smoother at
// several image sides, predicts each windowed mean with its own line store,
// and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module tb_rgb_box_smooth_3x3_unit;
  import bsm_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 200;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic            last;
    logic [9:0]      col;
    logic [9:0]      row;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } smoothed_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // in_red, in_green, in_blue
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // out_red, out_green, out_blue, out_row, out_col
  logic        m_axis_tlast;   // frame_last
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;       // image_side in [10:0]

  rgb_box_smooth_3x3_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  // Predictor state
  pixel_t    line_buf [3][MAX_SIDE];
  int        side_eff;
  int        cur_row, cur_col;
  pixel_t    pending_px[$];
  smoothed_t smoothed_q[$];
  int        n_fail;
  int        idle_cycles;
  bit        feed_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    n_fail++;
  endtask

  function automatic smoothed_t window_mean(input int rr, input int cc);
    smoothed_t s;
    int r0, r1, c0, c1, sr, sg, sb, n;
    r0 = (rr > 0) ? rr - 1 : 0;
    r1 = (rr + 1 < side_eff) ? rr + 1 : side_eff - 1;
    c0 = (cc > 0) ? cc - 1 : 0;
    c1 = (cc + 1 < side_eff) ? cc + 1 : side_eff - 1;
    sr = 0; sg = 0; sb = 0; n = 0;
    for (int i = r0; i <= r1; i++)
      for (int j = c0; j <= c1; j++) begin
        sr += line_buf[i % 3][j].red;
        sg += line_buf[i % 3][j].green;
        sb += line_buf[i % 3][j].blue;
        n++;
      end
    s.red   = CH_W'(sr / n);
    s.green = CH_W'(sg / n);
    s.blue  = CH_W'(sb / n);
    s.row   = 10'(rr);
    s.col   = 10'(cc);
    s.last  = (rr == side_eff - 1 && cc == side_eff - 1);
    return s;
  endfunction

  // Store the pixel and queue every window it completes
  task automatic predict_pixel(input pixel_t px);
    int r, c;
    r = cur_row;
    c = cur_col;
    line_buf[r % 3][c] = px;
    if (r >= 1 && c >= 1) smoothed_q.push_back(window_mean(r - 1, c - 1));
    if (r >= 1 && c == side_eff - 1) smoothed_q.push_back(window_mean(r - 1, c));
    if (r == side_eff - 1) begin
      if (c >= 1) smoothed_q.push_back(window_mean(r, c - 1));
      if (c == side_eff - 1) smoothed_q.push_back(window_mean(r, c));
    end
    if (c + 1 >= side_eff) begin
      cur_col = 0;
      cur_row = (r + 1 >= side_eff) ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
    end
  endtask

  // Driver: bursts of requests with random gaps
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_pixel(pixel_t'(s_axis_tdata));
      void'(pending_px.pop_front());
    end
    if (feed_on && ($urandom_range(0, 5) != 0)) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (pending_px.size() > 0) begin
          s_axis_tdata  <= {pending_px[0].blue, pending_px[0].green, pending_px[0].red};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end else if (!s_axis_tvalid && pending_px.size() > 0) begin
        s_axis_tdata  <= {pending_px[0].blue, pending_px[0].green, pending_px[0].red};
        s_axis_tvalid <= 1'b1;
      end
    end else if (s_axis_tvalid && s_axis_tready) begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Monitor with its own stall pattern
  always @(posedge clk_i) begin
    smoothed_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata[67:0]};
      if (smoothed_q.size() == 0) begin
        report("unexpected result row", got.row, -1);
      end else begin
        want = smoothed_q.pop_front();
        if (got.red   !== want.red)   report("red",   got.red,   want.red);
        if (got.green !== want.green) report("green", got.green, want.green);
        if (got.blue  !== want.blue)  report("blue",  got.blue,  want.blue);
        if (got.row   !== want.row)   report("row",   got.row,   want.row);
        if (got.col   !== want.col)   report("col",   got.col,   want.col);
        if (got.last  !== want.last)  report("last",  got.last,  want.last);
      end
    end
    m_axis_tready <= ($urandom_range(0, 15) < 11) || (idle_cycles[6] == 1'b1);
  end

  // Watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_side(input int value);
    @(posedge clk_i);
    cfg_data  <= 16'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    side_eff = (value == 0) ? 1 : (value > MAX_SIDE) ? MAX_SIDE : value;
    cur_row = 0;
    cur_col = 0;
  endtask

  task automatic wait_idle();
    while (pending_px.size() > 0 || smoothed_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic pixel_t rand_pixel(input int mode);
    pixel_t p;
    case (mode)
      0: p = '0;
      1: p = '1;
      default: p = pixel_t'(48'({$urandom, $urandom}));
    endcase
    return p;
  endfunction

  // Queue whole frames of one side
  task automatic queue_frames(input int nframes, input int mode);
    for (int f = 0; f < nframes; f++)
      for (int k = 0; k < side_eff * side_eff; k++)
        pending_px.push_back(rand_pixel((mode == 3) ? $urandom_range(0, 2) : mode));
  endtask

  initial begin
    int sides[7];
    sides = '{0, 1, 2, 3, 4, 7, 2047};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    n_fail = 0;
    idle_cycles = 0;
    feed_on = 1'b0;
    side_eff = 512;
    cur_row = 0;
    cur_col = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all-zero and all-ones frames, then tiny and out-of-range sides
    write_side(3);
    queue_frames(1, 0);
    queue_frames(1, 1);
    feed_on = 1'b1;
    wait_idle();
    foreach (sides[i]) begin
      write_side(sides[i]);
      if (side_eff <= 64) queue_frames(1, 3);
      wait_idle();
    end
    // Restart mid-frame: drop the partial frame by rewriting the side
    write_side(5);
    for (int k = 0; k < 7; k++) pending_px.push_back(rand_pixel(2));
    wait_idle();
    // Random frames over small sides
    repeat (6) begin
      write_side($urandom_range(1, 6));
      queue_frames($urandom_range(1, 2), 3);
      wait_idle();
    end
    // One large side, a short run of the first row only
    write_side(1024);
    for (int k = 0; k < 24; k++) pending_px.push_back(rand_pixel(2));
    wait_idle();
    write_side(512);
    feed_on = 1'b0;
    repeat (DRAIN) @(posedge clk_i);
    if (n_fail == 0 && smoothed_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
